FILE: src/set_associative_lru_cache_tags_assert.svh
// assertion macros for the lru cache tag block
`ifndef SET_ASSOCIATIVE_LRU_CACHE_TAGS_ASSERT_SVH
`define SET_ASSOCIATIVE_LRU_CACHE_TAGS_ASSERT_SVH
`ifndef SYNTHESIS
`define SALC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define SALC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define SALC_ASSERT(lbl, clk, rst_n, prop)
`define SALC_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

FILE: src/salc_pkg.sv
// shared types and constants of the lru cache tag block
package salc_pkg;
    localparam int TAG_W = 30;

    localparam logic [1:0] CFG_WAY_MODE   = 2'd0;
    localparam logic [1:0] CFG_BLOCK_LOG2 = 2'd1;
    localparam logic [1:0] CFG_LINES_LOG2 = 2'd2;

    localparam logic [1:0] MODE_DIRECT = 2'd0;
    localparam logic [1:0] MODE_FULL   = 2'd1;
    localparam logic [1:0] MODE_TWO    = 2'd2;
    localparam logic [1:0] MODE_FOUR   = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SEARCH,
        S_UPDATE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic sweep;
        logic load;
        logic scan;
        logic restart;
        logic update;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic sweep_last;
        logic scan_done;
        logic cfg_we;
    } t_sts;
endpackage

FILE: src/salc_ctrl.sv
// controller state machine of the lru cache tag block
`include "set_associative_lru_cache_tags_assert.svh"
module salc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  salc_pkg::t_sts i_sts,
    output salc_pkg::t_cmd o_cmd
);
    import salc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;
    logic   w_slot_free;

    assign o_in_ready  = (r_state == S_IDLE) && !i_sts.cfg_we;
    assign w_accept    = o_in_ready && i_in_valid;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.sweep_last && !i_sts.cfg_we) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_sts.cfg_we) n_state = S_CLEAR;
                else if (w_accept) n_state = S_SEARCH;
            end
            S_SEARCH: begin
                if (i_sts.scan_done) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_sts.scan_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_cmd         = '0;
        n_out_valid   = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_CLEAR:  o_cmd.sweep = 1'b1;
            S_IDLE:   o_cmd.load = w_accept;
            S_SEARCH: begin
                o_cmd.scan    = 1'b1;
                o_cmd.restart = i_sts.scan_done;
            end
            S_UPDATE: o_cmd.update = 1'b1;
            S_DONE: begin
                o_cmd.emit = w_slot_free;
                if (w_slot_free) n_out_valid = 1'b1;
            end
            default: o_cmd = '0;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `SALC_ASSERT_NEXT(a_accept_search, i_clk, i_rst_n, w_accept, r_state == S_SEARCH)
    `SALC_ASSERT_NEXT(a_cfg_clear, i_clk, i_rst_n,
        i_sts.cfg_we && (r_state == S_IDLE || r_state == S_CLEAR), r_state == S_CLEAR)
    `SALC_ASSERT(a_out_from_done, i_clk, i_rst_n,
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
endmodule

FILE: src/salc_dpath.sv
// tag and rank memories, address split and way scan of the lru cache tag block
module salc_dpath #(
    parameter int MAX_LINES = 256
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_idx,
    input  logic [3:0]     i_cfg_data,
    input  logic           i_op,
    input  logic [31:0]    i_address,
    input  salc_pkg::t_cmd i_cmd,
    output salc_pkg::t_sts o_sts,
    output logic           o_hit,
    output logic           o_fill,
    output logic           o_writeback
);
    import salc_pkg::*;

    localparam int IW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CAP = $clog2(MAX_LINES + 1) - 1;
    localparam logic [3:0]    CAP4 = 4'(CAP);
    localparam logic [IW-1:0] LAST = IW'(MAX_LINES - 1);
    localparam int EW = TAG_W + 2;

    // configuration registers
    logic [1:0] r_way_mode;
    logic [3:0] r_block_log2, r_lines_log2;
    logic [3:0] w_lg, w_wl, w_setbits, w_off;
    logic [4:0] w_tsh;
    logic [31:0] w_set, w_base32;
    logic       w_cfg_hit;

    // only a write to a known register changes the layout
    assign w_cfg_hit = i_cfg_we && ((i_cfg_idx == CFG_WAY_MODE) ||
                                    (i_cfg_idx == CFG_BLOCK_LOG2) ||
                                    (i_cfg_idx == CFG_LINES_LOG2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_way_mode   <= MODE_DIRECT;
            r_block_log2 <= 4'd2;
            r_lines_log2 <= 4'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WAY_MODE:   r_way_mode   <= i_cfg_data[1:0];
                CFG_BLOCK_LOG2: r_block_log2 <= i_cfg_data;
                CFG_LINES_LOG2: r_lines_log2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective layout
    always_comb begin
        w_lg = (r_lines_log2 > CAP4) ? CAP4 : r_lines_log2;
        unique case (r_way_mode)
            MODE_DIRECT: w_wl = 4'd0;
            MODE_FULL:   w_wl = w_lg;
            MODE_TWO:    w_wl = 4'd1;
            default:     w_wl = 4'd2;
        endcase
        if (w_wl > w_lg) w_wl = w_lg;
        w_setbits = w_lg - w_wl;
        w_off     = (r_block_log2 < 4'd2) ? 4'd2 : r_block_log2;
        w_tsh     = {1'b0, w_off} + {1'b0, w_setbits};
        w_set     = (i_address >> w_off) & ((32'd1 << w_setbits) - 32'd1);
        w_base32  = w_set << w_wl;
    end

    // latched item
    logic              r_op;
    logic [TAG_W-1:0]  r_tag;
    logic [IW-1:0]     r_base;
    logic [IW:0]       r_ways;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_tag  <= TAG_W'(i_address >> w_tsh);
            r_base <= w_base32[IW-1:0];
            r_ways <= (IW+1)'(1) << w_wl;
        end
    end

    // clearing sweep counter
    logic [IW-1:0] r_clr;
    logic          r_wipe;
    logic [IW-1:0] w_rank_mask;

    assign w_rank_mask = IW'(((IW+1)'(1) << w_wl) - (IW+1)'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr  <= '0;
            r_wipe <= 1'b1;
        end else if (w_cfg_hit) begin
            r_clr <= '0;
        end else if (i_cmd.sweep) begin
            r_clr <= r_clr + IW'(1);
            if (r_clr == LAST) r_wipe <= 1'b0;
        end
    end

    // scan pipeline: issue a read, evaluate it in the next cycle
    logic [IW:0]   r_cnt;
    logic          r_pv;
    logic [IW-1:0] r_pw;
    logic          w_issue;

    assign w_issue = (i_cmd.scan || i_cmd.update) && (r_cnt < r_ways);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pv  <= 1'b0;
        end else if (i_cmd.load || i_cmd.restart) begin
            r_cnt <= '0;
            r_pv  <= 1'b0;
        end else begin
            r_pv <= w_issue;
            if (w_issue) r_cnt <= r_cnt + (IW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_issue) r_pw <= r_cnt[IW-1:0];
    end

    // memories
    logic [EW-1:0] mem_t [MAX_LINES];
    logic [IW-1:0] mem_r [MAX_LINES];
    logic [EW-1:0] r_tq;
    logic [IW-1:0] r_rq;
    logic [IW-1:0] w_raddr, w_waddr;
    logic          w_twe, w_rwe;
    logic [EW-1:0] w_twd;
    logic [IW-1:0] w_rwd;

    assign w_raddr = r_base + r_cnt[IW-1:0];

    always_ff @(posedge i_clk) begin
        r_tq <= mem_t[w_raddr];
        r_rq <= mem_r[w_raddr];
        if (w_twe) mem_t[w_waddr] <= w_twd;
        if (w_rwe) mem_r[w_waddr] <= w_rwd;
    end

    // search bookkeeping
    logic             w_v, w_d;
    logic [TAG_W-1:0] w_t;
    logic             r_hit, r_finv;
    logic [IW-1:0]    r_hw, r_hrank, r_iw, r_irank, r_mw, r_mrank;
    logic             r_mdirty;
    logic [IW-1:0]    w_tw, w_trank;

    assign w_v = r_tq[EW-1];
    assign w_d = r_tq[EW-2];
    assign w_t = r_tq[TAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hit  <= 1'b0;
            r_finv <= 1'b0;
        end else if (i_cmd.scan && r_pv) begin
            if (!r_hit && w_v && (w_t == r_tag)) begin
                r_hit   <= 1'b1;
                r_hw    <= r_pw;
                r_hrank <= r_rq;
            end
            if (!w_v && (!r_finv || (r_rq < r_irank))) begin
                r_finv  <= 1'b1;
                r_iw    <= r_pw;
                r_irank <= r_rq;
            end
            if ((r_pw == '0) || (r_rq > r_mrank)) begin
                r_mw     <= r_pw;
                r_mrank  <= r_rq;
                r_mdirty <= w_v && w_d;
            end
        end
    end

    assign w_tw    = r_hit ? r_hw : (r_finv ? r_iw : r_mw);
    assign w_trank = r_hit ? r_hrank : (r_finv ? r_irank : r_mrank);

    // memory writes: sweep or rank move-to-front
    always_comb begin
        w_twe   = 1'b0;
        w_rwe   = 1'b0;
        w_waddr = r_base + r_pw;
        w_twd   = r_tq;
        w_rwd   = r_rq;
        if (i_cmd.sweep) begin
            w_waddr = r_clr;
            w_rwe   = 1'b1;
            w_rwd   = r_clr & w_rank_mask;
            w_twe   = r_wipe;
            w_twd   = '0;
        end else if (i_cmd.update && r_pv) begin
            w_rwe = 1'b1;
            if (r_pw == w_tw) begin
                w_rwd = '0;
                w_twe = 1'b1;
                if (r_hit) w_twd = {1'b1, w_d | r_op, w_t};
                else       w_twd = {1'b1, r_op, r_tag};
            end else if (r_rq < w_trank) begin
                w_rwd = r_rq + IW'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_hit       <= r_hit;
            o_fill      <= !r_hit;
            o_writeback <= !r_hit && !r_finv && r_mdirty;
        end
    end

    assign o_sts.sweep_last = (r_clr == LAST);
    assign o_sts.scan_done  = (r_cnt == r_ways) && !r_pv;
    assign o_sts.cfg_we     = w_cfg_hit;
endmodule

FILE: src/set_associative_lru_cache_tags.sv
// top level of the lru cache tag block
// Tag-only LRU cache model. An access (i_op, i_address) is a transfer on the
// input channel (i_in_valid / o_in_ready); one result (o_hit, o_fill,
// o_writeback) per access is a transfer on the output channel
// (o_out_valid / i_out_ready). Configuration is to be written by the user
// through i_cfg_we, i_cfg_idx, i_cfg_data while the block is idle; the
// block itself does not enforce this. One access is handled at a time. The
// set's ways are read from the tag and rank memories one way per cycle,
// once to search and once more to rewrite the ranks. The single read port
// of the way memories is why the ways are read one at a time.
// After reset a clearing pass invalidates every line and sets the ranks;
// a write to a known configuration register while idle or clearing starts
// a rank pass over every line. No access is taken during a pass.
// The result waits in an output register while the receiver stalls; the
// next access is taken, but its result is held back until the register
// has been emptied.
module set_associative_lru_cache_tags #(
    parameter int MAX_LINES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [31:0] i_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_hit,
    output logic        o_fill,
    output logic        o_writeback
);
    import salc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // controller
    salc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath
    salc_dpath #(.MAX_LINES(MAX_LINES)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_op),
        .i_address   (i_address),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_hit       (o_hit),
        .o_fill      (o_fill),
        .o_writeback (o_writeback)
    );
endmodule
